/* src/kdpc_pkg.sv */
// Shared types and constants for the key debounce and press classifier.
`default_nettype none
package kdpc_pkg;

  localparam int KEYS_DEF      = 8;
  localparam int TICK_BITS_DEF = 16;
  localparam int CFG_W         = 16;
  localparam int FIELD_W       = 8;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SHORT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LONG  = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd2;
  localparam logic [CFG_W-1:0] MAX_SHORT_RST = 16'd50;
  localparam logic [CFG_W-1:0] MIN_LONG_RST  = 16'd100;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_FIRST = 4'b0010,
    PH_WAIT  = 4'b0100,
    PH_HELD  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic short_ev;
    logic normal_ev;
    logic long_ev;
    logic held;
  } lane_res_t;

  typedef struct packed {
    logic [FIELD_W-1:0] short_events;
    logic [FIELD_W-1:0] normal_events;
    logic [FIELD_W-1:0] long_events;
    logic [FIELD_W-1:0] held_keys;
  } out_rec_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] max_short_ticks;
    logic [CFG_W-1:0] min_long_ticks;
  } cfg_t;

endpackage
`default_nettype wire

/* src/kdpc_lane.sv */
// One key lane: phase machine, debounce and hold counter, release classing.
`default_nettype none
module kdpc_lane #(
  parameter int TICK_BITS = kdpc_pkg::TICK_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic              pressed,
  input  wire kdpc_pkg::cfg_t    cfg,
  output kdpc_pkg::lane_res_t    res
);
  import kdpc_pkg::*;

  localparam int CMP_W = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;

  phase_t               phase;
  phase_t               phase_next;
  logic [TICK_BITS-1:0] ticks;
  logic [TICK_BITS-1:0] ticks_next;
  logic [CMP_W-1:0]     t_w;
  logic [CMP_W-1:0]     deb_w;
  logic [CMP_W-1:0]     short_w;
  logic [CMP_W-1:0]     long_w;
  logic                 full;

  assign t_w     = CMP_W'(ticks);
  assign deb_w   = CMP_W'(cfg.debounce_ticks);
  assign short_w = CMP_W'(cfg.max_short_ticks);
  assign long_w  = CMP_W'(cfg.min_long_ticks);
  assign full    = &ticks;

  always_comb begin
    phase_next    = phase;
    ticks_next    = ticks;
    res.short_ev  = 1'b0;
    res.normal_ev = 1'b0;
    res.long_ev   = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (pressed) begin
          phase_next = PH_FIRST;
          ticks_next = '0;
        end
      end
      PH_FIRST: begin
        phase_next = pressed ? PH_WAIT : PH_IDLE;
      end
      PH_WAIT: begin
        if (t_w < deb_w && !full) begin
          ticks_next = ticks + 1'b1;
        end else begin
          phase_next = PH_HELD;
          ticks_next = '0;
        end
      end
      PH_HELD: begin
        if (pressed) begin
          if (!full) begin
            ticks_next = ticks + 1'b1;
          end
        end else begin
          priority if (t_w < short_w) begin
            res.short_ev = 1'b1;
          end else if (t_w > long_w) begin
            res.long_ev = 1'b1;
          end else begin
            res.normal_ev = 1'b1;
          end
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        ticks_next = '0;
      end
    endcase
    res.held = (phase_next == PH_HELD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      ticks <= '0;
    end else if (step) begin
      phase <= phase_next;
      ticks <= ticks_next;
    end
  end

endmodule
`default_nettype wire

/* src/kdpc_merge.sv */
// Merge of lane results into one output item, with a two-entry output queue.
`default_nettype none
module kdpc_merge #(
  parameter int NUM_KEYS = kdpc_pkg::KEYS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    push_ready,
  input  wire kdpc_pkg::lane_res_t [NUM_KEYS-1:0] lane_res,
  output logic                                    pop_valid,
  input  wire logic                               pop_ready,
  output kdpc_pkg::out_rec_t                      rec
);
  import kdpc_pkg::*;

  out_rec_t   merged;
  out_rec_t   q [2];
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;
  logic       wr_slot;

  always_comb begin
    merged = '0;
    for (int j = 0; j < FIELD_W; j++) begin
      if (j < NUM_KEYS) begin
        merged.short_events[j]  = lane_res[j].short_ev;
        merged.normal_events[j] = lane_res[j].normal_ev;
        merged.long_events[j]   = lane_res[j].long_ev;
        merged.held_keys[j]     = lane_res[j].held;
      end
    end
  end

  assign pop        = pop_valid && pop_ready;
  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign rec        = q[0];
  assign wr_slot    = (count - {1'b0, pop}) != 2'd0;
  assign count_next = count + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q[0] <= (push && !wr_slot) ? merged : q[1];
    end else if (push && !wr_slot) begin
      q[0] <= merged;
    end
    if (push && wr_slot) begin
      q[1] <= merged;
    end
  end

endmodule
`default_nettype wire

/* src/key_debounce_press_classifier.sv */
// Top level: configuration registers, one lane per key, result merge.
// Each accepted item's result is written into the output queue.
// Throughput: one item per cycle while the output queue is not full; all key lanes update in the same cycle.
// A two-entry output queue keeps input accepted while a result waits.
// Reset (synchronous, rst high): all keys idle, counters zero, queue empty,
// registers back to debounce 2, short limit 50, long limit 100.
`default_nettype none
module key_debounce_press_classifier #(
  parameter int NUM_KEYS  = kdpc_pkg::KEYS_DEF,
  parameter int TICK_BITS = kdpc_pkg::TICK_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [kdpc_pkg::FIELD_W-1:0]   pressed_levels,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [kdpc_pkg::FIELD_W-1:0]        short_events,
  output logic [kdpc_pkg::FIELD_W-1:0]        normal_events,
  output logic [kdpc_pkg::FIELD_W-1:0]        long_events,
  output logic [kdpc_pkg::FIELD_W-1:0]        held_keys,
  input  wire logic                           cfg_wr_en,
  input  wire logic [kdpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kdpc_pkg::CFG_W-1:0]     cfg_data
);
  import kdpc_pkg::*;

  cfg_t                       cfg;
  logic                       step;
  lane_res_t [NUM_KEYS-1:0]   lane_res;
  out_rec_t                   rec;

  assign step = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks  <= DEBOUNCE_RST;
      cfg.max_short_ticks <= MAX_SHORT_RST;
      cfg.min_long_ticks  <= MIN_LONG_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DEBOUNCE:  cfg.debounce_ticks  <= cfg_data;
        REG_MAX_SHORT: cfg.max_short_ticks <= cfg_data;
        REG_MIN_LONG:  cfg.min_long_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
    logic lvl;
    if (i < FIELD_W) begin : g_pin
      assign lvl = pressed_levels[i];
    end else begin : g_nopin
      assign lvl = 1'b0;
    end
    kdpc_lane #(
      .TICK_BITS (TICK_BITS)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .step    (step),
      .pressed (lvl),
      .cfg     (cfg),
      .res     (lane_res[i])
    );
  end

  kdpc_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_ready (in_ready),
    .lane_res   (lane_res),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .rec        (rec)
  );

  assign short_events  = rec.short_events;
  assign normal_events = rec.normal_events;
  assign long_events   = rec.long_events;
  assign held_keys     = rec.held_keys;

endmodule
`default_nettype wire

/* src/kdpc_checker.sv */
// Port-level checks for the key debounce and press classifier, bound to the top.
`default_nettype none
module kdpc_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [kdpc_pkg::FIELD_W-1:0] short_events,
  input wire logic [kdpc_pkg::FIELD_W-1:0] normal_events,
  input wire logic [kdpc_pkg::FIELD_W-1:0] long_events,
  input wire logic [kdpc_pkg::FIELD_W-1:0] held_keys
);
  import kdpc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_class: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((short_events & normal_events) == '0) &&
                  ((short_events & long_events) == '0) &&
                  ((normal_events & long_events) == '0))
    else $error("key released with more than one class");

  a_release_not_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((held_keys & (short_events | normal_events | long_events)) == '0))
    else $error("released key still marked held");

endmodule

bind key_debounce_press_classifier kdpc_checker u_kdpc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .short_events  (short_events),
  .normal_events (normal_events),
  .long_events   (long_events),
  .held_keys     (held_keys)
);
`default_nettype wire

/* sim/tb.sv */
// Testbench for the key debounce and press classifier: directed, random and class-limit tests.
`default_nettype none
module tb;
  import kdpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0]     REG_NONE    = 2'd3;
  localparam logic [TICK_BITS_DEF-1:0] TICK_MAX    = '1;
  localparam int                       QUIET_LIMIT = 2000;
  localparam int                       PHASE_ITEMS = 140;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [FIELD_W-1:0]   pressed_levels = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [FIELD_W-1:0]   short_events;
  logic [FIELD_W-1:0]   normal_events;
  logic [FIELD_W-1:0]   long_events;
  logic [FIELD_W-1:0]   held_keys;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_data = '0;

  key_debounce_press_classifier u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pressed_levels(pressed_levels),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .short_events  (short_events),
    .normal_events (normal_events),
    .long_events   (long_events),
    .held_keys     (held_keys),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  phase_t                   lane_phase [KEYS_DEF];
  logic [TICK_BITS_DEF-1:0] lane_count [KEYS_DEF];
  cfg_t                     limits;
  out_rec_t                 pending_events [$];

  int idle_pct = 23;
  int stall_req = 0;
  int stall_left = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int press_left [KEYS_DEF];
  int gap_left [KEYS_DEF];

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic out_rec_t scan_tick(input logic [FIELD_W-1:0] levels);
    out_rec_t                 res;
    logic [TICK_BITS_DEF-1:0] t;
    res = '0;
    for (int k = 0; k < KEYS_DEF; k++) begin
      t = lane_count[k];
      case (lane_phase[k])
        PH_IDLE: begin
          if (levels[k]) begin
            lane_phase[k] = PH_FIRST;
            t = '0;
          end
        end
        PH_FIRST: begin
          lane_phase[k] = levels[k] ? PH_WAIT : PH_IDLE;
        end
        PH_WAIT: begin
          if (t < limits.debounce_ticks && t != TICK_MAX) begin
            t = t + 1'b1;
          end else begin
            lane_phase[k] = PH_HELD;
            t = '0;
          end
        end
        default: begin
          if (levels[k]) begin
            if (t != TICK_MAX) t = t + 1'b1;
          end else begin
            if (t < limits.max_short_ticks) res.short_events[k] = 1'b1;
            else if (t > limits.min_long_ticks) res.long_events[k] = 1'b1;
            else res.normal_events[k] = 1'b1;
            lane_phase[k] = PH_IDLE;
          end
        end
      endcase
      lane_count[k] = t;
      res.held_keys[k] = (lane_phase[k] == PH_HELD);
    end
    return res;
  endfunction

  // Each key cycles through a press of random length and a short release.
  function automatic logic [FIELD_W-1:0] next_levels(input int maxdur);
    logic [FIELD_W-1:0] v;
    v = '0;
    for (int k = 0; k < KEYS_DEF; k++) begin
      if (press_left[k] > 0) begin
        v[k] = 1'b1;
        press_left[k]--;
      end else if (gap_left[k] > 0) begin
        gap_left[k]--;
      end else begin
        v[k] = 1'b1;
        press_left[k] = int'($urandom_range(1, maxdur)) - 1;
        gap_left[k] = int'($urandom_range(1, 4));
      end
    end
    if ($urandom_range(0, 7) == 0) v ^= FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
    return v;
  endfunction

  task automatic flag_mismatch(input string what, input out_rec_t want, input out_rec_t got);
    if (mismatch_count < 10) begin
      $display("MISMATCH %s: expected short=%h normal=%h long=%h held=%h",
               what, want.short_events, want.normal_events, want.long_events, want.held_keys);
      $display("MISMATCH %s: got      short=%h normal=%h long=%h held=%h",
               what, got.short_events, got.normal_events, got.long_events, got.held_keys);
    end
    mismatch_count++;
  endtask

  task automatic send_levels(input logic [FIELD_W-1:0] levels);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pressed_levels <= levels;
    do @(posedge clk); while (!in_ready);
    pending_events.push_back(scan_tick(levels));
  endtask

  task automatic hold_levels(input logic [FIELD_W-1:0] levels, input int n);
    repeat (n) send_levels(levels);
  endtask

  task automatic drain_events();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] shrt,
                            input logic [CFG_W-1:0] lng);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_data <= deb;
    @(posedge clk);
    cfg_index <= REG_MAX_SHORT;
    cfg_data <= shrt;
    @(posedge clk);
    cfg_index <= REG_MIN_LONG;
    cfg_data <= lng;
    @(posedge clk);
    cfg_index <= REG_NONE;
    cfg_data <= CFG_W'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limits.debounce_ticks = deb;
    limits.max_short_ticks = shrt;
    limits.min_long_ticks = lng;
  endtask

  // Reset limits: first-press release, release during the wait, short release.
  task automatic test_first_press_and_wait();
    logic [FIELD_W-1:0] seq [8] = '{8'h01, 8'h00, 8'hFF, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00};
    foreach (seq[i]) send_levels(seq[i]);
    drain_events();
  endtask

  task automatic test_zero_limits();
    logic [FIELD_W-1:0] seq [11] = '{8'h0F, 8'h0F, 8'h0F, 8'h03, 8'h00, 8'hA0, 8'h80,
                                     8'h80, 8'h80, 8'h80, 8'h00};
    set_limits('0, '0, '0);
    foreach (seq[i]) send_levels(seq[i]);
    drain_events();
  endtask

  task automatic test_random_mix();
    logic [CFG_W-1:0] deb;
    logic [CFG_W-1:0] shrt;
    logic [CFG_W-1:0] lng;
    int               maxdur;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          deb = CFG_W'($urandom_range(0, 3));
          shrt = CFG_W'($urandom_range(2, 8));
          lng = shrt + CFG_W'($urandom_range(0, 8));
          maxdur = int'(deb) + int'(lng) + 6;
        end
        1: begin
          // overlapping limits: short class wins
          deb = CFG_W'($urandom_range(0, 2));
          shrt = CFG_W'($urandom_range(8, 16));
          lng = CFG_W'($urandom_range(0, 6));
          maxdur = int'(deb) + int'(shrt) + 8;
        end
        2: begin
          deb = '0;
          shrt = '0;
          lng = '0;
          maxdur = 8;
        end
        3: begin
          deb = DEBOUNCE_RST;
          shrt = MAX_SHORT_RST;
          lng = MIN_LONG_RST;
          maxdur = 110;
        end
        default: begin
          deb = CFG_W'($urandom_range(0, 3));
          shrt = '1;
          lng = '1;
          maxdur = 12;
        end
      endcase
      set_limits(deb, shrt, lng);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 0 && i == PHASE_ITEMS / 2) stall_req <= 300;
        if (p == 1 && i == PHASE_ITEMS / 2) drain_events();
        if (p == 2) idle_pct = (i >= 30 && i < 110) ? 0 : 23;
        send_levels(next_levels(maxdur));
      end
      drain_events();
    end
  endtask

  // Hold counts walked across both class limits, one press per count.
  task automatic test_class_limits();
    set_limits('0, 16'd10, 16'd20);
    for (int c = 8; c < 24; c++) begin
      hold_levels(8'hFF, 3 + c);
      hold_levels(8'h00, 2);
    end
    drain_events();
  endtask

  always @(posedge clk) begin
    if (stall_req != 0) begin
      stall_left = stall_req;
      stall_req <= 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    out_rec_t got;
    out_rec_t want;
    if (!rst && out_valid && out_ready) begin
      got = {short_events, normal_events, long_events, held_keys};
      if (pending_events.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_events.pop_front();
        if (want.short_events !== got.short_events || want.normal_events !== got.normal_events ||
            want.long_events !== got.long_events || want.held_keys !== got.held_keys)
          flag_mismatch("scan tick", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k < KEYS_DEF; k++) begin
      lane_phase[k] = PH_IDLE;
      lane_count[k] = '0;
      press_left[k] = 0;
      gap_left[k] = 0;
    end
    limits.debounce_ticks = DEBOUNCE_RST;
    limits.max_short_ticks = MAX_SHORT_RST;
    limits.min_long_ticks = MIN_LONG_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_first_press_and_wait();
    test_zero_limits();
    test_random_mix();
    test_class_limits();
    drain_events();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
src/kdpc_pkg.sv
src/kdpc_lane.sv
src/kdpc_merge.sv
src/key_debounce_press_classifier.sv
src/kdpc_checker.sv
sim/tb.sv
